>>> rtl/fltpw_pkg.sv
// Shared types and constants for the four-level page table walker.
package fltpw_pkg;

	localparam int unsigned ADDR_W      = 64;
	localparam int unsigned IDX_W       = 9;
	localparam int unsigned FRAME_LO    = 12;
	localparam int unsigned FRAME_HI    = 35;
	localparam int unsigned FRAME_W     = FRAME_HI - FRAME_LO + 1;
	localparam int unsigned GIG_LO      = 30;
	localparam int unsigned GIG_HI      = 51;
	localparam int unsigned GIG_W       = GIG_HI - GIG_LO + 1;
	localparam int unsigned PRESENT_BIT = 0;
	localparam int unsigned LARGE_BIT   = 7;
	localparam int unsigned ROOT_ALIGN_W = 4;

	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = 1;
	localparam int unsigned Q_CNT_W = 2;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 64;
	localparam logic REG_TABLE_ROOT = 1'b0;

	typedef enum logic {
		KIND_REQ  = 1'b0,
		KIND_RESP = 1'b1
	} kind_t;

	typedef enum logic {
		RES_READ = 1'b0,
		RES_DONE = 1'b1
	} res_kind_t;

	typedef logic [1:0] level_t;
	localparam level_t LVL_TOP  = 2'd0;
	localparam level_t LVL_GIG  = 2'd1;
	localparam level_t LVL_MEG  = 2'd2;
	localparam level_t LVL_LAST = 2'd3;

	typedef struct packed {
		kind_t                kind;
		logic [ADDR_W-1:0]    va;
		logic [IDX_W-1:0]     idx0;
		logic                 ok;
		logic                 present;
		logic                 page_sz;
		logic [FRAME_W-1:0]   frame;
		logic [GIG_W-1:0]     gig;
	} cmd_t;

	typedef struct packed {
		res_kind_t            kind;
		logic [ADDR_W-1:0]    addr;
		logic                 fault;
	} res_t;

endpackage

>>> rtl/fltpw_front.sv
// Front end: decodes incoming items and queues them for the walk engine.
module fltpw_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    kind,
	input  logic [63:0]             virtual_address,
	input  logic [63:0]             read_data,
	input  logic                    read_ok,
	output logic                    full,
	output logic                    cmd_valid,
	output fltpw_pkg::cmd_t         cmd,
	input  logic                    cmd_pop
);
	import fltpw_pkg::*;

	cmd_t               q_mem [Q_DEPTH];
	cmd_t               dec;
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               wr_en;
	logic               rd_en;

	always_comb begin
		dec.kind    = kind_t'(kind);
		dec.va      = virtual_address;
		dec.idx0    = virtual_address[47:39];
		dec.ok      = read_ok;
		dec.present = read_data[PRESENT_BIT];
		dec.page_sz = read_data[LARGE_BIT];
		dec.frame   = read_data[FRAME_HI:FRAME_LO];
		dec.gig     = read_data[GIG_HI:GIG_LO];
	end

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;
	assign cmd       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/fltpw_back.sv
// Walk engine: holds walk state, forms read requests and results, queues results.
module fltpw_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [63:0]             table_root,
	input  logic                    cmd_valid,
	input  fltpw_pkg::cmd_t         cmd,
	output logic                    cmd_pop,
	input  logic                    pop,
	output logic                    empty,
	output fltpw_pkg::res_t         res
);
	import fltpw_pkg::*;

	logic               busy_q;
	level_t             level_q;
	logic [ADDR_W-1:0]  hva_q;

	logic               busy_d;
	level_t             level_d;
	logic               load_hva;
	logic               res_en;
	res_kind_t          r_kind;
	logic               r_fault;
	logic [ADDR_W-1:0]  add_a;
	logic [ADDR_W-1:0]  add_b;
	logic [ADDR_W-1:0]  frame_addr;
	logic [IDX_W-1:0]   next_idx;
	level_t             level_inc;
	res_t               res_new;

	res_t               q_mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               out_pop;
	logic               wr_en;

	assign empty   = (count_q == '0);
	assign out_pop = pop && !empty;
	assign cmd_pop = cmd_valid && ((count_q != Q_CNT_W'(Q_DEPTH)) || out_pop);

	assign frame_addr = {{(ADDR_W-FRAME_HI-1){1'b0}}, cmd.frame, {FRAME_LO{1'b0}}};
	assign level_inc  = level_q + 2'd1;

	always_comb begin
		case (level_inc)
			LVL_GIG:  next_idx = hva_q[38:30];
			LVL_MEG:  next_idx = hva_q[29:21];
			LVL_LAST: next_idx = hva_q[20:12];
			default:  next_idx = hva_q[47:39];
		endcase
	end

	always_comb begin
		busy_d   = busy_q;
		level_d  = level_q;
		load_hva = 1'b0;
		res_en   = 1'b0;
		r_kind   = RES_DONE;
		r_fault  = 1'b0;
		add_a    = '0;
		add_b    = '0;
		if (cmd_pop) begin
			if (cmd.kind == KIND_REQ) begin
				if (!busy_q) begin
					res_en = 1'b1;
					if (table_root[ROOT_ALIGN_W-1:0] != '0) begin
						r_fault = 1'b1;
					end else begin
						busy_d   = 1'b1;
						level_d  = LVL_TOP;
						load_hva = 1'b1;
						r_kind   = RES_READ;
						add_a    = table_root;
						add_b    = {{(ADDR_W-IDX_W-3){1'b0}}, cmd.idx0, 3'b000};
					end
				end
			end else if (busy_q) begin
				res_en = 1'b1;
				if (!cmd.ok) begin
					r_fault = 1'b1;
				end else if (level_q != LVL_LAST) begin
					if (!cmd.present) begin
						r_fault = 1'b1;
					end else if (level_q == LVL_GIG && cmd.page_sz) begin
						add_a = {{(ADDR_W-GIG_HI-1){1'b0}}, cmd.gig, {GIG_LO{1'b0}}};
						add_b = {{(ADDR_W-GIG_LO){1'b0}}, hva_q[GIG_LO-1:0]};
					end else if (level_q == LVL_MEG && cmd.page_sz) begin
						add_a = frame_addr;
						add_b = {{(ADDR_W-21){1'b0}}, hva_q[20:0]};
					end else begin
						r_kind  = RES_READ;
						level_d = level_inc;
						add_a   = frame_addr;
						add_b   = {{(ADDR_W-IDX_W-3){1'b0}}, next_idx, 3'b000};
					end
				end else if (cmd.frame == '0) begin
					r_fault = 1'b1;
				end else begin
					add_a = frame_addr;
					add_b = {{(ADDR_W-FRAME_LO){1'b0}}, hva_q[FRAME_LO-1:0]};
				end
				if (r_kind == RES_DONE) begin
					busy_d  = 1'b0;
					level_d = LVL_TOP;
				end
			end
			if (r_fault) begin
				busy_d  = 1'b0;
				level_d = LVL_TOP;
			end
		end
	end

	always_comb begin
		res_new.kind  = r_kind;
		res_new.addr  = r_fault ? '0 : (add_a + add_b);
		res_new.fault = r_fault;
	end

	assign wr_en = res_en;
	assign res   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (load_hva) begin
			hva_q <= cmd.va;
		end
		if (wr_en) begin
			q_mem[wr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			level_q  <= LVL_TOP;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			busy_q  <= busy_d;
			level_q <= level_d;
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, out_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/four_level_page_table_walker.sv
// Top level of the four-level page table walker: config register and the two halves.
//
// Usage: program table_root over the APB port (64-bit register at address 0)
// while the walker is idle. Push translate requests (kind 0) and memory read
// responses (kind 1) on the input queue port; an item is taken when push is
// high and full is low. Results leave through the output queue port: the
// oldest result is shown while empty is low and goes when pop is high.
// A result is either a read request for the next table entry (result_kind 0)
// or a finished translation with physical_address or fault (result_kind 1).
// An item enters a two-entry decode queue; the walk engine handles one item per
// cycle, the sustained rate, while the result queue has room or is popped. A taken
// item is registered in the decode queue, and its result in the result queue, before it is shown.
// Requests that arrive mid-walk and responses that arrive while idle give no
// result. When pop stays low the two-entry result queue fills, the engine
// stops, the decode queue fills and full rises; nothing is dropped.
// Reset clears the walk state, both queues and table_root.
module four_level_page_table_walker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fltpw_pkg::PADDR_W-1:0]   paddr,
	input  logic [fltpw_pkg::PDATA_W-1:0]   pwdata,
	output logic [fltpw_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	input  logic                            push,
	output logic                            full,
	input  logic                            kind,
	input  logic [63:0]                     virtual_address,
	input  logic [63:0]                     read_data,
	input  logic                            read_ok,
	output logic                            empty,
	input  logic                            pop,
	output logic                            result_kind,
	output logic [63:0]                     read_address,
	output logic [63:0]                     physical_address,
	output logic                            fault
);
	import fltpw_pkg::*;

	logic [ADDR_W-1:0] table_root_q;
	logic              reg_sel;
	logic              cmd_valid;
	logic              cmd_pop;
	cmd_t              cmd;
	res_t              res;

	assign pready  = 1'b1;
	assign reg_sel = paddr[PADDR_W-1];
	assign prdata  = (reg_sel == REG_TABLE_ROOT) ? table_root_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_root_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel == REG_TABLE_ROOT) begin
			table_root_q <= pwdata;
		end
	end

	fltpw_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.kind            (kind),
		.virtual_address (virtual_address),
		.read_data       (read_data),
		.read_ok         (read_ok),
		.full            (full),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_pop         (cmd_pop)
	);

	fltpw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.table_root (table_root_q),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.pop        (pop),
		.empty      (empty),
		.res        (res)
	);

	assign result_kind      = res.kind;
	assign fault            = res.fault;
	assign read_address     = (res.kind == RES_READ) ? res.addr : '0;
	assign physical_address = (res.kind == RES_DONE && !res.fault) ? res.addr : '0;

endmodule

>>> dv/four_level_page_table_walker_checker.sv
`timescale 1ns / 100ps
// Checker for the page table walker: predicts every result and compares it with the output queue.
module four_level_page_table_walker_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fltpw_pkg::PADDR_W-1:0]   paddr,
	input  logic [fltpw_pkg::PDATA_W-1:0]   pwdata,
	input  logic                            pready,
	input  logic                            push,
	input  logic                            full,
	input  logic                            kind,
	input  logic [63:0]                     virtual_address,
	input  logic [63:0]                     read_data,
	input  logic                            read_ok,
	input  logic                            empty,
	input  logic                            pop,
	input  logic                            result_kind,
	input  logic [63:0]                     read_address,
	input  logic [63:0]                     physical_address,
	input  logic                            fault,
	output int                              pending,
	output int                              mismatches
);
	import fltpw_pkg::*;

	localparam logic [PADDR_W-1:0] ROOT_ADDR = PADDR_W'(8 * REG_TABLE_ROOT);
	localparam logic [63:0] FRAME_MASK =
		((64'd1 << (FRAME_HI + 1)) - 64'd1) & ~((64'd1 << FRAME_LO) - 64'd1);
	localparam logic [63:0] GIG_MASK =
		((64'd1 << (GIG_HI + 1)) - 64'd1) & ~((64'd1 << GIG_LO) - 64'd1);
	localparam int TOP_SHIFT = FRAME_LO + 3 * IDX_W;

	typedef struct packed {
		res_kind_t   kind;
		logic [63:0] read_address;
		logic [63:0] physical_address;
		logic        fault;
	} walk_result_t;

	walk_result_t pending_results[$];
	logic [63:0]  root;
	logic [63:0]  held_va;
	logic         walking;
	level_t       depth;
	int           errs;

	function automatic logic [63:0] low_bits(input logic [63:0] v, input int n);
		return v & ((64'd1 << n) - 64'd1);
	endfunction

	function automatic logic [63:0] entry_offset(input logic [63:0] va, input level_t lv);
		return low_bits(va >> (TOP_SHIFT - IDX_W * lv), IDX_W) << 3;
	endfunction

	function automatic walk_result_t walk_read(input logic [63:0] addr);
		walk_result_t r;
		r.kind             = RES_READ;
		r.read_address     = addr;
		r.physical_address = '0;
		r.fault            = 1'b0;
		return r;
	endfunction

	function automatic walk_result_t walk_done(input logic [63:0] pa, input logic flt);
		walk_result_t r;
		walking            = 1'b0;
		depth              = LVL_TOP;
		r.kind             = RES_DONE;
		r.read_address     = '0;
		r.physical_address = flt ? 64'd0 : pa;
		r.fault            = flt;
		return r;
	endfunction

	function automatic bit walk_step(input kind_t k, input logic [63:0] va,
			input logic [63:0] entry, input logic ok, output walk_result_t r);
		logic [63:0] frame;
		frame = entry & FRAME_MASK;
		r = '0;
		if (k == KIND_REQ) begin
			if (walking)
				return 1'b0;
			if (root[ROOT_ALIGN_W-1:0] != '0) begin
				r = walk_done('0, 1'b1);
				return 1'b1;
			end
			walking = 1'b1;
			depth   = LVL_TOP;
			held_va = va;
			r = walk_read(root + entry_offset(va, LVL_TOP));
			return 1'b1;
		end
		if (!walking)
			return 1'b0;
		if (!ok)
			r = walk_done('0, 1'b1);
		else if (depth != LVL_LAST) begin
			if (!entry[PRESENT_BIT])
				r = walk_done('0, 1'b1);
			else if (depth == LVL_GIG && entry[LARGE_BIT])
				r = walk_done((entry & GIG_MASK) + low_bits(held_va, GIG_LO), 1'b0);
			else if (depth == LVL_MEG && entry[LARGE_BIT])
				r = walk_done(frame + low_bits(held_va, FRAME_LO + IDX_W), 1'b0);
			else begin
				depth = level_t'(depth + 1);
				r = walk_read(frame + entry_offset(held_va, depth));
			end
		end else if (frame == '0)
			r = walk_done('0, 1'b1);
		else
			r = walk_done(frame + low_bits(held_va, FRAME_LO), 1'b0);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		walk_result_t want;
		if (!arst_n) begin
			root    = '0;
			held_va = '0;
			walking = 1'b0;
			depth   = LVL_TOP;
			errs    = 0;
			pending_results.delete();
			pending    <= 0;
			mismatches <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ROOT_ADDR)
				root = pwdata;
			if (push && !full) begin
				if (walk_step(kind_t'(kind), virtual_address, read_data, read_ok, want))
					pending_results.push_back(want);
			end
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					errs++;
					$error("unexpected result: result_kind %0d read_address %h",
						result_kind, read_address);
				end else begin
					want = pending_results.pop_front();
					if (result_kind !== want.kind) begin
						errs++;
						$error("result_kind expected %0d got %0d", want.kind, result_kind);
					end
					if (read_address !== want.read_address) begin
						errs++;
						$error("read_address expected %h got %h",
							want.read_address, read_address);
					end
					if (physical_address !== want.physical_address) begin
						errs++;
						$error("physical_address expected %h got %h",
							want.physical_address, physical_address);
					end
					if (fault !== want.fault) begin
						errs++;
						$error("fault expected %0d got %0d", want.fault, fault);
					end
				end
			end
			pending    <= pending_results.size();
			mismatches <= errs;
		end
	end

endmodule

>>> dv/tb_four_level_page_table_walker.sv
`timescale 1ns / 100ps
// Testbench top for the page table walker: clock, reset, root writes, walk stimulus and verdict.
module tb_four_level_page_table_walker;
	import fltpw_pkg::*;

	localparam logic [PADDR_W-1:0] ROOT_ADDR = PADDR_W'(8 * REG_TABLE_ROOT);
	localparam logic [63:0] ENTRY_NEXT = 64'hFFFF_FFFF_FFFF_FF7F;
	localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int ITEM_TARGET = 1900;
	localparam int CYCLE_LIMIT = 400000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               push = 1'b0;
	logic               full;
	logic               kind = 1'b0;
	logic [63:0]        virtual_address = '0;
	logic [63:0]        read_data = '0;
	logic               read_ok = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic               result_kind;
	logic [63:0]        read_address;
	logic [63:0]        physical_address;
	logic               fault;
	int                 pending;
	int                 mismatches;

	int     cycle_count = 0;
	int     pop_hold = 0;
	bit     idle_on = 1'b1;
	bit     root_ok = 1'b1;
	bit     stim_walking = 1'b0;
	level_t stim_depth = LVL_TOP;
	int     counted = 0;

	four_level_page_table_walker dut (.*);
	four_level_page_table_walker_checker walk_check (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			pop_hold <= $urandom_range(0, 3);
			pop <= 1'b0;
		end else
			pop <= 1'b1;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] make_entry(input level_t lv);
		logic [63:0] e;
		e = rand64();
		e[PRESENT_BIT] = $urandom_range(0, 9) != 0;
		if (lv == LVL_GIG || lv == LVL_MEG)
			e[LARGE_BIT] = $urandom_range(0, 3) == 0;
		if (lv == LVL_LAST && $urandom_range(0, 9) == 0)
			e[FRAME_HI:FRAME_LO] = '0;
		return e;
	endfunction

	task automatic write_root(input logic [63:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ROOT_ADDR;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		root_ok = v[ROOT_ALIGN_W-1:0] == '0;
	endtask

	task automatic push_item(input kind_t k, input logic [63:0] va, input logic [63:0] d,
			input logic ok);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push            <= 1'b1;
		kind            <= k;
		virtual_address <= va;
		read_data       <= d;
		read_ok         <= ok;
		@(posedge clk);
		while (full) @(posedge clk);
		// follow the walk so random entries suit the level being read
		if (k == KIND_REQ) begin
			if (!stim_walking) begin
				counted++;
				if (root_ok) begin
					stim_walking = 1'b1;
					stim_depth = LVL_TOP;
				end
			end
		end else if (stim_walking) begin
			counted++;
			if (!ok || stim_depth == LVL_LAST || !d[PRESENT_BIT] ||
					((stim_depth == LVL_GIG || stim_depth == LVL_MEG) && d[LARGE_BIT]))
				stim_walking = 1'b0;
			else
				stim_depth = level_t'(stim_depth + 1);
		end
	endtask

	task automatic push_req(input logic [63:0] va);
		push_item(KIND_REQ, va, rand64(), 1'($urandom_range(0, 1)));
	endtask

	task automatic push_resp(input logic [63:0] d, input logic ok);
		push_item(KIND_RESP, rand64(), d, ok);
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_walk();
		if ($urandom_range(0, 9) == 0)
			push_resp(rand64(), 1'($urandom_range(0, 1)));
		push_req(rand64());
		while (stim_walking) begin
			if ($urandom_range(0, 19) == 0)
				push_req(rand64());
			push_resp(make_entry(stim_depth), $urandom_range(0, 15) != 0);
		end
	endtask

	initial begin : stimulus
		logic [63:0] roots [8];
		int p;
		roots = '{64'd0, 64'hFFFF_FFFF_FFFF_FFF0, ALL_ONES, 64'h8000_0000_0000_0000,
			rand64() & ~64'hF, rand64(), 64'h8, rand64() & ~64'hF};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_root(64'd0);

		// stray response while idle
		push_resp(ALL_ONES, 1'b1);
		// 4K page
		push_req(ALL_ONES);
		repeat (3) push_resp(ENTRY_NEXT, 1'b1);
		push_resp(ALL_ONES, 1'b1);
		// 1G page
		push_req(64'd0);
		push_resp(ENTRY_NEXT, 1'b1);
		push_resp(ALL_ONES, 1'b1);
		// 2M page
		push_req(rand64());
		push_resp(64'h81, 1'b1);
		push_resp(ENTRY_NEXT, 1'b1);
		push_resp(ALL_ONES, 1'b1);
		// failed read
		push_req(rand64());
		push_resp(ALL_ONES, 1'b0);
		// not present
		push_req(rand64());
		push_resp(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
		// request mid-walk, then last level without present bit
		push_req(rand64());
		push_resp(ENTRY_NEXT, 1'b1);
		push_req(rand64());
		push_resp(ENTRY_NEXT, 1'b1);
		push_resp(ENTRY_NEXT, 1'b1);
		push_resp(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
		// empty frame at last level
		push_req(rand64());
		repeat (3) push_resp(ENTRY_NEXT, 1'b1);
		push_resp(64'hFFFF_FFF0_0000_0FFF, 1'b1);
		settle();

		for (p = 0; p < 8; p++) begin
			if (p == 7)
				idle_on = 1'b0;
			write_root(roots[p]);
			while (counted < ITEM_TARGET * (p + 1) / 8) begin
				random_walk();
				if (idle_on && $urandom_range(0, 199) == 0)
					settle();
			end
			settle();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
rtl/fltpw_pkg.sv
rtl/fltpw_front.sv
rtl/fltpw_back.sv
rtl/four_level_page_table_walker.sv
dv/four_level_page_table_walker_checker.sv
dv/tb_four_level_page_table_walker.sv
